// ===== hw/rtl/lcgr_pkg.sv =====
package lcgr_pkg;

  // Generator constants
  localparam logic [31:0] LCG_MULT  = 32'd1664525;
  localparam logic [31:0] LCG_INC   = 32'd30399561;
  localparam logic [31:0] FLAT_MASK = 32'h7fff_ffff;

  // Request opcodes
  localparam logic [1:0] OP_RAW     = 2'd0;
  localparam logic [1:0] OP_FLAT    = 2'd1;
  localparam logic [1:0] OP_UNIFORM = 2'd2;

  // Dividend width for uniform draws (state shifted right by one)
  localparam int unsigned DIV_W = 31;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] range_min;
    logic signed [31:0] range_max;
  } req_t;

  typedef struct packed {
    logic [31:0] random_word;
    logic        span_error;
  } rsp_t;

  // How the back end finishes a queued job
  typedef enum logic [1:0] {
    JOB_PASS     = 2'd0,  // word is final
    JOB_SPAN_ERR = 2'd1,  // zero span, answer zero with error
    JOB_UNIFORM  = 2'd2   // word is dividend, reduce mod span and add base
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [31:0] word;
    logic [31:0] span;
    logic [31:0] base;
  } job_t;

endpackage

// ===== hw/rtl/lcgr_front.sv =====
module lcgr_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          seed_wr,
  input  logic [31:0]   seed_value,
  input  logic          req_take,
  input  lcgr_pkg::req_t req,
  output lcgr_pkg::job_t job
);

  logic [31:0] gen_state;
  logic [31:0] gen_state_next;
  logic [31:0] advanced;
  logic [31:0] span;
  logic        step;

  // LCG advance and wrapped span
  assign advanced = gen_state * lcgr_pkg::LCG_MULT + lcgr_pkg::LCG_INC;
  assign span     = 32'(req.range_max) - 32'(req.range_min) + 32'd1;

  // Classify the request into a back-end job
  always_comb begin
    step     = 1'b1;
    job.kind = lcgr_pkg::JOB_PASS;
    job.word = advanced;
    job.span = span;
    job.base = 32'(req.range_min);
    unique case (req.opcode)
      lcgr_pkg::OP_RAW: begin
        job.word = advanced;
      end
      lcgr_pkg::OP_FLAT: begin
        job.word = advanced & lcgr_pkg::FLAT_MASK;
      end
      lcgr_pkg::OP_UNIFORM: begin
        if (span == 32'd0) begin
          job.kind = lcgr_pkg::JOB_SPAN_ERR;
          job.word = 32'd0;
        end else begin
          job.kind = lcgr_pkg::JOB_UNIFORM;
          job.word = {1'b0, advanced[31:1]};
        end
      end
      default: begin
        // unused opcode: zero answer, state holds
        step     = 1'b0;
        job.word = 32'd0;
      end
    endcase
  end

  // Generator state: seed write loads, accepted request advances
  always_comb begin
    gen_state_next = gen_state;
    if (seed_wr) begin
      gen_state_next = seed_value;
    end else if (req_take && step) begin
      gen_state_next = advanced;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_state <= 32'd0;
    end else begin
      gen_state <= gen_state_next;
    end
  end

endmodule

// ===== hw/rtl/lcgr_queue.sv =====
module lcgr_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lcgr_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output lcgr_pkg::job_t pop_job
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  lcgr_pkg::job_t slots [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_job   = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/lcgr_back.sv =====
module lcgr_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_avail,
  input  lcgr_pkg::job_t job,
  output logic           job_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output lcgr_pkg::rsp_t out_data
);

  localparam int unsigned STEP_W = $clog2(lcgr_pkg::DIV_W);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t      state;
  logic [31:0] rem;
  logic [lcgr_pkg::DIV_W-1:0] dividend;
  logic [31:0] span;
  logic [31:0] base;
  logic [STEP_W-1:0] steps_left;
  logic [32:0] trial;
  logic [32:0] diff;
  logic [31:0] rem_next;

  assign job_pop   = (state == S_IDLE) && job_avail;
  assign out_valid = (state == S_DONE);

  // One restoring remainder step per cycle
  assign trial    = {rem, dividend[lcgr_pkg::DIV_W-1]};
  assign diff     = trial - {1'b0, span};
  assign rem_next = diff[32] ? trial[31:0] : diff[31:0];

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (job_avail) begin
            state <= (job.kind == lcgr_pkg::JOB_UNIFORM) ? S_DIV : S_DONE;
          end
        end
        S_DIV: begin
          if (steps_left == '0) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath and result register
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        rem        <= 32'd0;
        dividend   <= job.word[lcgr_pkg::DIV_W-1:0];
        span       <= job.span;
        base       <= job.base;
        steps_left <= STEP_W'(lcgr_pkg::DIV_W - 1);
        out_data.random_word <= job.word;
        out_data.span_error  <= (job.kind == lcgr_pkg::JOB_SPAN_ERR);
      end
      S_DIV: begin
        rem        <= rem_next;
        dividend   <= {dividend[lcgr_pkg::DIV_W-2:0], 1'b0};
        steps_left <= steps_left - STEP_W'(1);
        if (steps_left == '0) begin
          out_data.random_word <= rem_next + base;
          out_data.span_error  <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hw/rtl/lcg_random_ranged_core.sv =====
// Channel   Direction  Handshake             Payload
// seed      in         seed_wr               seed_value (32 bits)
// request   in         in_valid / in_stall   in_data  (lcgr_pkg::req_t)
// result    out        out_valid / out_stall out_data (lcgr_pkg::rsp_t)
//
// Raw and flat requests pass the back end's load and output states; uniform requests
// also run 31 remainder steps of the bit-serial divider between load and output.
// The front end advances the generator on accept and queues QUEUE_DEPTH jobs,
// so requests are taken while the back end divides or a result waits.
// rst is synchronous: generator state returns to zero, queue and sequencer empty.
// in_stall rises only when the job queue is full.
module lcg_random_ranged_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           seed_wr,
  input  logic [31:0]    seed_value,
  input  logic           in_valid,
  output logic           in_stall,
  input  lcgr_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output lcgr_pkg::rsp_t out_data
);

  lcgr_pkg::job_t front_job;
  lcgr_pkg::job_t back_job;
  logic           q_full;
  logic           q_avail;
  logic           q_pop;
  logic           take;

  // Request transaction accepted when queue has room
  assign in_stall = q_full;
  assign take     = in_valid && !q_full;

  lcgr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .seed_wr    (seed_wr),
    .seed_value (seed_value),
    .req_take   (take),
    .req        (in_data),
    .job        (front_job)
  );

  lcgr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .push_job  (front_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_avail),
    .pop_job   (back_job)
  );

  lcgr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_avail (q_avail),
    .job       (back_job),
    .job_pop   (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== tb/tb_lcg_random_ranged_core.sv =====
`timescale 1ns / 1ps

module tb_lcg_random_ranged_core;

  // Generator recurrence and output mask
  localparam logic [31:0] GEN_MULT = 32'd1664525;
  localparam logic [31:0] GEN_INC  = 32'd30399561;
  localparam logic [31:0] LOW31    = 32'h7fff_ffff;

  // The package leaves the fourth opcode unnamed; the block answers it with zero
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam logic [31:0] S_MIN = 32'h8000_0000;
  localparam logic [31:0] S_MAX = 32'h7fff_ffff;

  localparam int PHASES     = 8;
  localparam int PHASE_ITEMS = 60;
  localparam int LONG_HOLD  = 150;
  localparam int DRAIN      = 40;

  // Directed row: request, whether the answer is typed in, typed answer
  typedef struct packed {
    lcgr_pkg::req_t req;
    logic           known;
    lcgr_pkg::rsp_t want;
  } dir_row_t;

  localparam int DIR_N = 20;
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    {lcgr_pkg::OP_RAW,     32'd0,    32'd0,         1'b1, 32'd30399561, 1'b0},
    {lcgr_pkg::OP_FLAT,    S_MAX,    S_MIN,         1'b0, 32'd0,        1'b0},
    {OP_SPARE,             S_MIN,    S_MAX,         1'b1, 32'd0,        1'b0},
    {lcgr_pkg::OP_UNIFORM, 32'd0,    32'd0,         1'b1, 32'd0,        1'b0},
    {lcgr_pkg::OP_UNIFORM, S_MIN,    S_MAX,         1'b1, 32'd0,        1'b1},
    {lcgr_pkg::OP_UNIFORM, 32'd5,    32'd4,         1'b1, 32'd0,        1'b1},
    {lcgr_pkg::OP_UNIFORM, S_MAX,    S_MAX,         1'b1, S_MAX,        1'b0},
    {lcgr_pkg::OP_UNIFORM, S_MIN,    S_MIN,         1'b1, S_MIN,        1'b0},
    {lcgr_pkg::OP_UNIFORM, -32'sd10, 32'sd10,       1'b0, 32'd0,        1'b0},
    {lcgr_pkg::OP_UNIFORM, 32'sd100, -32'sd100,     1'b0, 32'd0,        1'b0},
    {lcgr_pkg::OP_UNIFORM, S_MIN,    32'h7fff_fffe, 1'b0, 32'd0,        1'b0},
    {lcgr_pkg::OP_UNIFORM, 32'd0,    S_MAX,         1'b0, 32'd0,        1'b0},
    {lcgr_pkg::OP_UNIFORM, -32'sd1,  -32'sd2,       1'b1, 32'd0,        1'b1},
    {OP_SPARE,             32'd0,    -32'sd1,       1'b1, 32'd0,        1'b0},
    {lcgr_pkg::OP_RAW,     -32'sd1,  -32'sd1,       1'b0, 32'd0,        1'b0},
    {lcgr_pkg::OP_FLAT,    32'd0,    32'd0,         1'b0, 32'd0,        1'b0},
    {lcgr_pkg::OP_UNIFORM, S_MAX,    S_MIN,         1'b0, 32'd0,        1'b0},
    {lcgr_pkg::OP_UNIFORM, -32'sd1,  32'sd0,        1'b0, 32'd0,        1'b0},
    {OP_SPARE,             32'd0,    32'd0,         1'b1, 32'd0,        1'b0},
    {lcgr_pkg::OP_RAW,     32'd0,    32'd0,         1'b0, 32'd0,        1'b0}
  };

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           seed_wr;
  logic [31:0]    seed_value;
  logic           in_valid;
  logic           in_stall;
  lcgr_pkg::req_t in_data;
  logic           out_valid;
  logic           out_stall;
  lcgr_pkg::rsp_t out_data;

  // Predictor state and the draws still owed by the block
  logic [31:0]    gen_state;
  lcgr_pkg::rsp_t pending_draws [$];
  int             mismatches = 0;

  bit idle_on   = 1'b1;
  bit gaps_on   = 1'b1;
  bit long_hold = 1'b0;

  lcg_random_ranged_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .seed_wr    (seed_wr),
    .seed_value (seed_value),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Advance the generator and work out the draw for one request
  function automatic lcgr_pkg::rsp_t next_draw(input lcgr_pkg::req_t r);
    lcgr_pkg::rsp_t d;
    logic [31:0]    lo;
    logic [31:0]    hi;
    logic [31:0]    span;
    d = '0;
    lo = r.range_min;
    hi = r.range_max;
    if (r.opcode != OP_SPARE) begin
      gen_state = gen_state * GEN_MULT + GEN_INC;
    end
    case (r.opcode)
      lcgr_pkg::OP_RAW: begin
        d.random_word = gen_state;
      end
      lcgr_pkg::OP_FLAT: begin
        d.random_word = gen_state & LOW31;
      end
      lcgr_pkg::OP_UNIFORM: begin
        span = hi - lo + 32'd1;
        if (span == 32'd0) begin
          d.span_error = 1'b1;
        end else begin
          d.random_word = ({1'b0, gen_state[31:1]} % span) + lo;
        end
      end
      default: begin
        d = '0;
      end
    endcase
    return d;
  endfunction

  // Random request: half of them uniform draws, over varied range shapes
  function automatic lcgr_pkg::req_t rand_req();
    lcgr_pkg::req_t r;
    int unsigned    op_pick;
    int unsigned    shape;
    op_pick = $urandom_range(0, 9);
    shape = $urandom_range(0, 9);
    r.range_min = $urandom;
    r.range_max = $urandom;
    if (op_pick < 2) r.opcode = lcgr_pkg::OP_RAW;
    else if (op_pick < 4) r.opcode = lcgr_pkg::OP_FLAT;
    else if (op_pick == 4) r.opcode = OP_SPARE;
    else r.opcode = lcgr_pkg::OP_UNIFORM;
    if (shape < 4) begin
      r.range_max = r.range_min + $urandom_range(0, 200);
    end else if (shape == 4) begin
      // span wraps to zero
      r.range_max = r.range_min - 1;
    end else if (shape == 5) begin
      r.range_max = r.range_min;
    end else if (shape == 6) begin
      r.range_min = $urandom_range(0, 2000) - 1000;
      r.range_max = r.range_min + $urandom_range(0, 2000);
    end
    return r;
  endfunction

  // Offer one request, wait for the transaction, record the owed draw
  task automatic push_req(input lcgr_pkg::req_t r, input logic known,
                          input lcgr_pkg::rsp_t want);
    lcgr_pkg::rsp_t pred;
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = next_draw(r);
    pending_draws.push_back(known ? want : pred);
  endtask

  // Random sender idle burst between requests
  task automatic sender_gap();
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic load_seed(input logic [31:0] v);
    seed_wr    <= 1'b1;
    seed_value <= v;
    @(posedge clk);
    seed_wr <= 1'b0;
    gen_state = v;
  endtask

  task automatic wait_drained();
    while (pending_draws.size() != 0) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    logic [31:0] seed;
    in_valid   = 1'b0;
    in_data    = '0;
    seed_wr    = 1'b0;
    seed_value = '0;
    gen_state  = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    load_seed(32'd0);
    for (int i = 0; i < DIR_N; i++) begin
      push_req(DIR_TAB[i].req, DIR_TAB[i].known, DIR_TAB[i].want);
      sender_gap();
    end
    in_valid <= 1'b0;
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: seed = 32'hffff_ffff;
        1: seed = 32'd0;
        2: seed = S_MIN;
        default: seed = $urandom;
      endcase
      idle_on = (p < PHASES - 2);
      // one phase pushes back to back against a long receiver hold-off
      long_hold = (p == 3);
      gaps_on = idle_on && !long_hold;
      load_seed(seed);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        push_req(rand_req(), 1'b0, '0);
        sender_gap();
      end
      in_valid <= 1'b0;
      wait_drained();
    end

    gaps_on = 1'b0;
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Receiver stall bursts, plus the long hold-off when requested
  initial begin
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Check each result transaction against the oldest owed draw
  always @(posedge clk) begin
    lcgr_pkg::rsp_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_draws.size() == 0) begin
        $error("unexpected result: random_word %h span_error %b",
               out_data.random_word, out_data.span_error);
        mismatches++;
      end else begin
        want = pending_draws.pop_front();
        if (out_data.random_word !== want.random_word) begin
          $error("random_word: expected %h, got %h",
                 want.random_word, out_data.random_word);
          mismatches++;
        end
        if (out_data.span_error !== want.span_error) begin
          $error("span_error: expected %b, got %b",
                 want.span_error, out_data.span_error);
          mismatches++;
        end
      end
    end
  end

  // Hang guard
  initial begin
    #1_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
